// ===== rtl/srwf_pkg.sv =====
// Shared types, register codes and speed tables for the sector range wall-follow block.
package srwf_pkg;

   // Motion modes chosen at the end of each scan
   typedef enum logic [1:0] {
      MODE_FIND_WALL     = 2'd0,
      MODE_TURN_LEFT     = 2'd1,
      MODE_STRAIGHT_LEFT = 2'd2,
      MODE_BACKWARDS     = 2'd3
   } mode_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_NEAR_THRESHOLD = 2'd0,
      CSR_CLEAR_MARGIN   = 2'd1,
      CSR_HIT_THRESHOLD  = 2'd2,
      CSR_SAMPLES        = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int THRESH_BITS    = 16;
   localparam int SAMPLES_BITS   = 12;
   localparam int SPLIT_BITS     = 11;  // floor(4095/3) = 1365
   localparam int SPLIT2_BITS    = 12;  // 2 * 1365 = 2730
   localparam int LIN_BITS       = 11;
   localparam int ANG_BITS       = 12;

   // Reset values of the configuration registers
   localparam logic [THRESH_BITS-1:0]  NEAR_RESET    = 16'd500;
   localparam logic [THRESH_BITS-1:0]  MARGIN_RESET  = 16'd200;
   localparam logic [THRESH_BITS-1:0]  HIT_RESET     = 16'd100;
   localparam logic [SAMPLES_BITS-1:0] SAMPLES_RESET = 12'd360;
   localparam logic [SPLIT_BITS-1:0]   SPLIT_RESET   = 11'd120;
   localparam logic [SPLIT2_BITS-1:0]  SPLIT2_RESET  = 12'd240;

   // floor(x/3) for 12-bit x as (x * 2731) >> 13
   localparam int DIV3_MULT_BITS = 12;
   localparam int DIV3_PROD_BITS = SAMPLES_BITS + DIV3_MULT_BITS;
   localparam logic [DIV3_MULT_BITS-1:0] DIV3_MULT = 12'd2731;
   localparam int DIV3_SHIFT = 13;

   // Threshold registers as seen by the decision logic
   typedef struct packed {
      logic [THRESH_BITS-1:0] near_mm;
      logic [THRESH_BITS-1:0] margin_mm;
      logic [THRESH_BITS-1:0] hit_mm;
   } thresh_type;

   // Linear speed command per mode, mm/s
   function automatic logic signed [LIN_BITS-1:0] lin_speed(input mode_type m);
      logic signed [LIN_BITS-1:0] v;
      case (m)
         MODE_FIND_WALL:     v = 11'sd300;
         MODE_TURN_LEFT:     v = 11'sd0;
         MODE_STRAIGHT_LEFT: v = 11'sd750;
         MODE_BACKWARDS:     v = -11'sd1000;
         default:            v = 11'sd0;
      endcase
      return v;
   endfunction

   // Angular speed command per mode, mrad/s
   function automatic logic signed [ANG_BITS-1:0] ang_speed(input mode_type m);
      logic signed [ANG_BITS-1:0] v;
      case (m)
         MODE_FIND_WALL:     v = -12'sd1500;
         MODE_TURN_LEFT:     v = 12'sd1000;
         MODE_STRAIGHT_LEFT: v = 12'sd100;
         MODE_BACKWARDS:     v = 12'sd0;
         default:            v = 12'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/srwf_req_if.sv =====
// Range sample channel: valid/ready with one sample per transaction.
interface srwf_req_if #(
   parameter int RANGE_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [RANGE_BITS-1:0] range_mm;
   logic                  scan_start;

   modport source (output valid, output range_mm, output scan_start, input ready);
   modport sink   (input valid, input range_mm, input scan_start, output ready);
endinterface

// ===== rtl/srwf_rsp_if.sv =====
// Motion command channel: valid/ready with one mode and speed pair per transaction.
interface srwf_rsp_if;
   logic                                      valid;
   logic                                      ready;
   srwf_pkg::mode_type                        mode;
   logic signed [srwf_pkg::LIN_BITS-1:0]      linear_speed_mm_s;
   logic signed [srwf_pkg::ANG_BITS-1:0]      angular_speed_mrad_s;

   modport source (output valid, output mode, output linear_speed_mm_s,
                   output angular_speed_mrad_s, input ready);
   modport sink   (input valid, input mode, input linear_speed_mm_s,
                   input angular_speed_mrad_s, output ready);
endinterface

// ===== rtl/srwf_decide.sv =====
// Ordered threshold chain that picks the motion mode from the three sector minima.
module srwf_decide #(
   parameter int RANGE_BITS = 16
) (
   input  srwf_pkg::thresh_type   thr,
   input  logic [RANGE_BITS-1:0]  right_min,
   input  logic [RANGE_BITS-1:0]  front_min,
   input  logic [RANGE_BITS-1:0]  left_min,
   input  srwf_pkg::mode_type     prev_mode,
   output srwf_pkg::mode_type     mode
);

   // Compare width covers the ranges and the 17-bit near+margin sum
   localparam int CW = (RANGE_BITS > srwf_pkg::THRESH_BITS + 1) ?
                       RANGE_BITS : srwf_pkg::THRESH_BITS + 1;

   logic [CW-1:0] f, l, r, t, c, h;

   assign f = CW'(front_min);
   assign l = CW'(left_min);
   assign r = CW'(right_min);
   assign t = CW'(thr.near_mm);
   assign c = CW'(thr.near_mm) + CW'(thr.margin_mm);
   assign h = CW'(thr.hit_mm);

   // First test that holds wins; otherwise keep the previous mode
   always_comb begin
      if (f > t && l > t && r > t) begin
         mode = srwf_pkg::MODE_FIND_WALL;
      end else if (f < t && l > c && r > c) begin
         mode = srwf_pkg::MODE_TURN_LEFT;
      end else if (f > t && l > t && r < t) begin
         mode = srwf_pkg::MODE_STRAIGHT_LEFT;
      end else if (f > t && l < t && r > t) begin
         mode = srwf_pkg::MODE_FIND_WALL;
      end else if (f < t && l > c && r < t) begin
         mode = srwf_pkg::MODE_TURN_LEFT;
      end else if (f < t && l < t && r > t) begin
         mode = srwf_pkg::MODE_FIND_WALL;
      end else if (f < t && l < t && r < t) begin
         mode = srwf_pkg::MODE_TURN_LEFT;
      end else if (f > t && l < t && r < t) begin
         mode = srwf_pkg::MODE_FIND_WALL;
      end else if (f <= h || l <= h || r <= h) begin
         mode = srwf_pkg::MODE_BACKWARDS;
      end else begin
         mode = prev_mode;
      end
   end

endmodule

// ===== rtl/sector_range_wall_follow_mode.sv =====
// Top level: sector minima tracking over a range scan and motion mode selection.
// A sample waits in the input register until the result register is free or drained;
//   a sample that ends a scan then loads the command. Throughput: one sample per clock
//   unless a command stalls, set by the single min-compare and decision pass.
// Reset (synchronous): registers to defaults, minima to all ones, index to 0,
//   mode to find wall, both pipeline stages empty.
module sector_range_wall_follow_mode #(
   parameter int RANGE_BITS = 16,
   parameter int INDEX_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   srwf_req_if.sink                              req,
   srwf_rsp_if.source                            rsp,
   input  logic                                  csr_we,
   input  logic [srwf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srwf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // Index compare width: holds idx+1 and the 12-bit scan length
   localparam int IW = (INDEX_BITS + 1 > srwf_pkg::SAMPLES_BITS) ?
                       INDEX_BITS + 1 : srwf_pkg::SAMPLES_BITS;

   // Configuration
   logic [srwf_pkg::THRESH_BITS-1:0]    near_ff, near_in;
   logic [srwf_pkg::THRESH_BITS-1:0]    margin_ff, margin_in;
   logic [srwf_pkg::THRESH_BITS-1:0]    hit_ff, hit_in;
   logic [srwf_pkg::SAMPLES_BITS-1:0]   sps_ff, sps_in;
   logic [srwf_pkg::SPLIT_BITS-1:0]     split_ff, split_in;
   logic [srwf_pkg::SPLIT2_BITS-1:0]    split2_ff, split2_in;
   logic [srwf_pkg::DIV3_PROD_BITS-1:0] div3_prod;
   logic [srwf_pkg::SPLIT_BITS-1:0]     div3_quot;

   // Input stage
   logic                  in_valid_ff, in_valid_in;
   logic [RANGE_BITS-1:0] range_ff, range_in;
   logic                  start_ff, start_in;

   // Scan state
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [RANGE_BITS-1:0] right_ff, right_in;
   logic [RANGE_BITS-1:0] front_ff, front_in;
   logic [RANGE_BITS-1:0] left_ff, left_in;
   srwf_pkg::mode_type    mode_ff, mode_in;

   // Output stage
   logic                  out_valid_ff, out_valid_in;
   srwf_pkg::mode_type    out_mode_ff, out_mode_in;

   // Datapath
   logic                  advance;
   logic                  process;
   logic [INDEX_BITS-1:0] idx_eff;
   logic [IW-1:0]         idx_ext;
   logic [IW-1:0]         idx_next;
   logic                  in_right, in_front, in_left;
   logic                  last;
   logic [RANGE_BITS-1:0] right_eff, front_eff, left_eff;
   logic [RANGE_BITS-1:0] right_new, front_new, left_new;
   srwf_pkg::mode_type    mode_next;
   srwf_pkg::thresh_type  thr;

   // Sector size from the scan length, by reciprocal multiply
   assign div3_prod = srwf_pkg::DIV3_PROD_BITS'(csr_wdata[srwf_pkg::SAMPLES_BITS-1:0]) *
                      srwf_pkg::DIV3_PROD_BITS'(srwf_pkg::DIV3_MULT);
   assign div3_quot = div3_prod[srwf_pkg::DIV3_SHIFT +: srwf_pkg::SPLIT_BITS];

   // Register writes
   always_comb begin
      near_in   = near_ff;
      margin_in = margin_ff;
      hit_in    = hit_ff;
      sps_in    = sps_ff;
      split_in  = split_ff;
      split2_in = split2_ff;
      if (csr_we) begin
         case (srwf_pkg::csr_index_type'(csr_index))
            srwf_pkg::CSR_NEAR_THRESHOLD: near_in   = csr_wdata;
            srwf_pkg::CSR_CLEAR_MARGIN:   margin_in = csr_wdata;
            srwf_pkg::CSR_HIT_THRESHOLD:  hit_in    = csr_wdata;
            srwf_pkg::CSR_SAMPLES: begin
               sps_in    = csr_wdata[srwf_pkg::SAMPLES_BITS-1:0];
               split_in  = div3_quot;
               split2_in = {div3_quot, 1'b0};
            end
            default: ;
         endcase
      end
   end

   // Handshake: a stage moves whenever the result register is free or drained
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign process   = in_valid_ff && advance;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      range_in    = range_ff;
      start_in    = start_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         if (req.valid) begin
            range_in = req.range_mm;
            start_in = req.scan_start;
         end
      end
   end

   // Scan start clears the state ahead of this sample
   assign idx_eff   = start_ff ? '0 : idx_ff;
   assign right_eff = start_ff ? '1 : right_ff;
   assign front_eff = start_ff ? '1 : front_ff;
   assign left_eff  = start_ff ? '1 : left_ff;

   // Sector select and end of scan
   assign idx_ext  = IW'(idx_eff);
   assign idx_next = idx_ext + IW'(1);
   assign in_right = idx_ext < IW'(split_ff);
   assign in_front = !in_right && (idx_ext < IW'(split2_ff));
   assign in_left  = !in_right && !in_front;
   assign last     = idx_next >= IW'(sps_ff);

   // Running minima
   assign right_new = (in_right && range_ff < right_eff) ? range_ff : right_eff;
   assign front_new = (in_front && range_ff < front_eff) ? range_ff : front_eff;
   assign left_new  = (in_left  && range_ff < left_eff)  ? range_ff : left_eff;

   assign thr.near_mm   = near_ff;
   assign thr.margin_mm = margin_ff;
   assign thr.hit_mm    = hit_ff;

   srwf_decide #(
      .RANGE_BITS (RANGE_BITS)
   ) u_decide (
      .thr       (thr),
      .right_min (right_new),
      .front_min (front_new),
      .left_min  (left_new),
      .prev_mode (mode_ff),
      .mode      (mode_next)
   );

   // Scan state and result register updates
   always_comb begin
      idx_in       = idx_ff;
      right_in     = right_ff;
      front_in     = front_ff;
      left_in      = left_ff;
      mode_in      = mode_ff;
      out_mode_in  = out_mode_ff;
      out_valid_in = advance ? (process && last) : out_valid_ff;
      if (process) begin
         if (last) begin
            idx_in      = '0;
            right_in    = '1;
            front_in    = '1;
            left_in     = '1;
            mode_in     = mode_next;
            out_mode_in = mode_next;
         end else begin
            idx_in   = idx_next[INDEX_BITS-1:0];
            right_in = right_new;
            front_in = front_new;
            left_in  = left_new;
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff      <= srwf_pkg::NEAR_RESET;
         margin_ff    <= srwf_pkg::MARGIN_RESET;
         hit_ff       <= srwf_pkg::HIT_RESET;
         sps_ff       <= srwf_pkg::SAMPLES_RESET;
         split_ff     <= srwf_pkg::SPLIT_RESET;
         split2_ff    <= srwf_pkg::SPLIT2_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         right_ff     <= '1;
         front_ff     <= '1;
         left_ff      <= '1;
         mode_ff      <= srwf_pkg::MODE_FIND_WALL;
      end else begin
         near_ff      <= near_in;
         margin_ff    <= margin_in;
         hit_ff       <= hit_in;
         sps_ff       <= sps_in;
         split_ff     <= split_in;
         split2_ff    <= split2_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         right_ff     <= right_in;
         front_ff     <= front_in;
         left_ff      <= left_in;
         mode_ff      <= mode_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      range_ff    <= range_in;
      start_ff    <= start_in;
      out_mode_ff <= out_mode_in;
   end

   // Result outputs
   assign rsp.valid                = out_valid_ff;
   assign rsp.mode                 = out_mode_ff;
   assign rsp.linear_speed_mm_s    = srwf_pkg::lin_speed(out_mode_ff);
   assign rsp.angular_speed_mrad_s = srwf_pkg::ang_speed(out_mode_ff);

`ifndef SYNTHESIS
   // A pending command always carries the current mode
   a_rsp_mode_current: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.mode == mode_ff)
      else $error("pending command differs from current mode");

   // No scan can end while a command is stalled
   a_mode_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(mode_ff))
      else $error("mode changed while command stalled");

   // End of scan leaves cleared minima and index
   a_scan_cleared: assert property (@(posedge clock) disable iff (reset)
      process && last |=> idx_ff == '0 && right_ff == '1 && front_ff == '1 && left_ff == '1)
      else $error("scan state not cleared at end of scan");

   // Sector size is floor of the scan length over three
   a_split_exact: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_we) |-> (14'(split_ff) * 14'd3 <= 14'(sps_ff)) &&
                         (14'(split_ff) * 14'd3 + 14'd3 > 14'(sps_ff)) &&
                         (split2_ff == {split_ff, 1'b0}))
      else $error("sector size does not match scan length");
`endif

endmodule
